// File: design/mrk_pkg.sv
// ----------------------------------------------------------------------------
// mrk_pkg - shared types and constants
// Sizes of the sorted cell chain, cell commands and controller states.
// ----------------------------------------------------------------------------
package mrk_pkg;

   // store and field sizes
   localparam int MAX_ITEMS = 32;
   localparam int VALUE_W   = 16;
   localparam int GROUP_W   = 6;
   localparam int INDEX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [VALUE_W-1:0]   value;
   } cell_ctrl_type;

   // window tracker control
   typedef struct packed {
      logic start;
      logic update;
   } win_ctrl_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// File: design/min_range_of_k_sorted_unit.sv
// Loading: one value per cycle while busy is low; each value is inserted in order, or dropped
// when the store is full. Closing: the closing transaction starts a scan that shifts the
// chain while a window fits, then strobes the result; busy stays high until that strobe.
// The scan time is set by the chain shifting one position per cycle past the tap cell.
// Reset: synchronous, empties the store, clears the overflow mark and sets group_size to 1.
// ----------------------------------------------------------------------------
// min_range_of_k_sorted_unit - smallest spread of group_size sorted values
// Sorted insertion chain, window scan by left shifting, result register.
// ----------------------------------------------------------------------------
module min_range_of_k_sorted_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mrk_pkg::VALUE_W-1:0]     req_value,
   input  logic                            req_is_last,
   output logic                            rsp_strobe,
   output logic [mrk_pkg::VALUE_W-1:0]     rsp_min_difference,
   output logic                            rsp_found,
   output logic                            rsp_overflow,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mrk_pkg::GROUP_W-1:0]     csr_group_size
);
   import mrk_pkg::*;

   state_type           state_ff, state_in;
   logic [GROUP_W-1:0]  group_ff;
   logic                dropped_ff, dropped_in;
   logic                strobe_ff;
   logic [VALUE_W-1:0]  min_diff_ff;
   logic                found_ff, overflow_ff;

   cell_ctrl_type       cell_ctrl;
   win_ctrl_type        win_ctrl;
   logic [GROUP_W-1:0]  group_eff;
   logic                group_ok;
   logic [INDEX_W-1:0]  tap_index;
   logic [VALUE_W-1:0]  head_value, tap_value, best;
   logic                tap_valid, full, win_found;
   logic                accept, window_ok, emit;

   assign accept = start & ~busy;
   assign busy   = (state_ff != ST_IDLE);
   assign csr_ready = ~busy;

   // a group size of zero counts as one; beyond the store it never fits
   assign group_eff = (group_ff == '0) ? GROUP_W'(1) : group_ff;
   assign group_ok  = (int'(group_eff) <= MAX_ITEMS);
   assign tap_index = INDEX_W'(group_eff - GROUP_W'(1));
   assign window_ok = tap_valid & group_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept & req_is_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!window_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      cell_ctrl.op    = CELL_HOLD;
      cell_ctrl.value = req_value;
      win_ctrl.start  = 1'b0;
      win_ctrl.update = 1'b0;
      emit            = 1'b0;
      dropped_in      = dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               win_ctrl.start = 1'b1;
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  cell_ctrl.op = CELL_INSERT;
               end
            end
         end
         ST_SCAN: begin
            if (window_ok) begin
               cell_ctrl.op    = CELL_SHIFT;
               win_ctrl.update = 1'b1;
            end else begin
               cell_ctrl.op = CELL_CLEAR;
               emit         = 1'b1;
               dropped_in   = 1'b0;
            end
         end
         default: begin
            cell_ctrl.op = CELL_HOLD;
         end
      endcase
   end

   mrk_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (cell_ctrl),
      .tap_index  (tap_index),
      .head_value (head_value),
      .tap_value  (tap_value),
      .tap_valid  (tap_valid),
      .full       (full)
   );

   mrk_window u_window (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (win_ctrl),
      .head_value (head_value),
      .tap_value  (tap_value),
      .best       (best),
      .found      (win_found)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         group_ff   <= GROUP_W'(1);
         dropped_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
         strobe_ff  <= emit;
         if (csr_valid & csr_ready) begin
            group_ff <= csr_group_size;
         end
      end
   end

   // result register, one transaction per closed set
   always_ff @(posedge clock) begin
      if (emit) begin
         min_diff_ff <= win_found ? best : '0;
         found_ff    <= win_found;
         overflow_ff <= dropped_ff;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_min_difference = min_diff_ff;
   assign rsp_found          = found_ff;
   assign rsp_overflow       = overflow_ff;

`ifndef SYNTHESIS
   // a result only follows the end of a scan
   a_strobe_after_scan: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == ST_SCAN))
      else $error("result strobe without a finished scan");

   // no group found means a zero spread
   a_zero_when_not_found: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && !found_ff |-> min_diff_ff == '0)
      else $error("spread reported for an unmet group");

   // a value that does not close the set keeps the unit free
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_is_last |=> !busy)
      else $error("unit went busy on a loading transaction");

   // the chain is never inserted into while scanning
   a_no_insert_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cell_ctrl.op != CELL_INSERT)
      else $error("insert during window scan");
`endif

endmodule

// File: design/mrk_cell.sv
// ----------------------------------------------------------------------------
// mrk_cell - one slot of the sorted chain
// Holds one value and its valid bit; on insert it either keeps its value,
// takes the new value or takes its left neighbour's; on shift it takes its
// right neighbour's; on clear it drops its valid bit.
// ----------------------------------------------------------------------------
module mrk_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  mrk_pkg::cell_ctrl_type          ctrl,
   input  logic [mrk_pkg::VALUE_W-1:0]     left_value,
   input  logic                            left_valid,
   input  logic                            left_gt,
   input  logic [mrk_pkg::VALUE_W-1:0]     right_value,
   input  logic                            right_valid,
   output logic [mrk_pkg::VALUE_W-1:0]     value,
   output logic                            valid,
   output logic                            gt
);
   import mrk_pkg::*;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               valid_ff, valid_in;

   // this slot holds a value larger than the incoming one
   assign gt = valid_ff & (value_ff > ctrl.value);

   // next slot contents
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (left_gt) begin
               value_in = left_value;
               valid_in = 1'b1;
            end else if (gt | (~valid_ff & left_valid)) begin
               value_in = ctrl.value;
               valid_in = 1'b1;
            end
         end
         CELL_SHIFT: begin
            value_in = right_value;
            valid_in = right_valid;
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// File: design/mrk_chain.sv
// ----------------------------------------------------------------------------
// mrk_chain - row of sorted cells
// Keeps the values in ascending order from cell 0 upwards and exposes the
// head cell and one selected tap cell for the window scan.
// ----------------------------------------------------------------------------
module mrk_chain (
   input  logic                            clock,
   input  logic                            reset,
   input  mrk_pkg::cell_ctrl_type          ctrl,
   input  logic [mrk_pkg::INDEX_W-1:0]     tap_index,
   output logic [mrk_pkg::VALUE_W-1:0]     head_value,
   output logic [mrk_pkg::VALUE_W-1:0]     tap_value,
   output logic                            tap_valid,
   output logic                            full
);
   import mrk_pkg::*;

   logic [VALUE_W-1:0] value_w [MAX_ITEMS];
   logic               valid_w [MAX_ITEMS];
   logic               gt_w    [MAX_ITEMS];

   // cells with their neighbour links; the ends see an always-filled left
   // side and an empty right side
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic [VALUE_W-1:0] lv, rv;
      logic               lvalid, lgt, rvalid;

      if (i == 0) begin : g_first
         assign lv     = '0;
         assign lvalid = 1'b1;
         assign lgt    = 1'b0;
      end else begin : g_inner_l
         assign lv     = value_w[i-1];
         assign lvalid = valid_w[i-1];
         assign lgt    = gt_w[i-1];
      end

      if (i == MAX_ITEMS-1) begin : g_last
         assign rv     = '0;
         assign rvalid = 1'b0;
      end else begin : g_inner_r
         assign rv     = value_w[i+1];
         assign rvalid = valid_w[i+1];
      end

      mrk_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_value  (lv),
         .left_valid  (lvalid),
         .left_gt     (lgt),
         .right_value (rv),
         .right_valid (rvalid),
         .value       (value_w[i]),
         .valid       (valid_w[i]),
         .gt          (gt_w[i])
      );
   end

   assign head_value = value_w[0];
   assign tap_value  = value_w[tap_index];
   assign tap_valid  = valid_w[tap_index];
   assign full       = valid_w[MAX_ITEMS-1];

endmodule

// File: design/mrk_window.sv
// ----------------------------------------------------------------------------
// mrk_window - running minimum of window spreads
// Takes one window (tap minus head) per update and keeps the smallest.
// ----------------------------------------------------------------------------
module mrk_window (
   input  logic                            clock,
   input  logic                            reset,
   input  mrk_pkg::win_ctrl_type           ctrl,
   input  logic [mrk_pkg::VALUE_W-1:0]     head_value,
   input  logic [mrk_pkg::VALUE_W-1:0]     tap_value,
   output logic [mrk_pkg::VALUE_W-1:0]     best,
   output logic                            found
);
   import mrk_pkg::*;

   logic [VALUE_W-1:0] best_ff, best_in, spread;
   logic               found_ff, found_in;

   // sorted order keeps tap >= head, so no borrow
   assign spread = tap_value - head_value;

   always_comb begin
      best_in  = best_ff;
      found_in = found_ff;
      if (ctrl.start) begin
         best_in  = '1;
         found_in = 1'b0;
      end else if (ctrl.update) begin
         found_in = 1'b1;
         if (spread < best_ff) begin
            best_in = spread;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign best  = best_ff;
   assign found = found_ff;

endmodule

// File: test/min_range_of_k_sorted_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_range_of_k_sorted_unit_tb - self-checking bench for the spread unit
// Loads sets of values through the start/busy port and writes group_size
// through the csr channel between phases. A model of the sorted store
// predicts each result, and a checker compares every strobed result with
// the oldest prediction. Directed sets come first, then random sets.
// ----------------------------------------------------------------------------
module min_range_of_k_sorted_unit_tb;

   localparam int VW          = mrk_pkg::VALUE_W;
   localparam int GW          = mrk_pkg::GROUP_W;
   localparam int DEPTH       = mrk_pkg::MAX_ITEMS;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [VW-1:0] min_difference;
      logic          found;
      logic          overflow;
   } spread_result_type;

   // DUT ports
   logic          clock;
   logic          reset          = 1'b1;
   logic          start          = 1'b0;
   logic          busy;
   logic [VW-1:0] req_value      = '0;
   logic          req_is_last    = 1'b0;
   logic          rsp_strobe;
   logic [VW-1:0] rsp_min_difference;
   logic          rsp_found;
   logic          rsp_overflow;
   logic          csr_valid      = 1'b0;
   logic          csr_ready;
   logic [GW-1:0] csr_group_size = '0;

   // model of the sorted store
   logic [VW-1:0] model_store [DEPTH];
   int            model_count;
   bit            model_dropped;
   logic [GW-1:0] model_group;

   spread_result_type expected_spread_q [$];
   int                err_count   = 0;
   int                cycle_count = 0;
   bit                idle_en     = 1'b1;

   min_range_of_k_sorted_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_value          (req_value),
      .req_is_last        (req_is_last),
      .rsp_strobe         (rsp_strobe),
      .rsp_min_difference (rsp_min_difference),
      .rsp_found          (rsp_found),
      .rsp_overflow       (rsp_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_group_size     (csr_group_size)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // insert one value, close the set on last and queue the spread
   function automatic void update_spread_model(input logic [VW-1:0] v, input logic last);
      int                pos;
      int                g;
      int                best;
      int                d;
      spread_result_type r;
      if (model_count >= DEPTH) begin
         model_dropped = 1'b1;
      end else begin
         pos = model_count;
         while (pos > 0 && model_store[pos-1] > v) begin
            model_store[pos] = model_store[pos-1];
            pos--;
         end
         model_store[pos] = v;
         model_count++;
      end
      if (last) begin
         g    = (model_group == 0) ? 1 : int'(model_group);
         best = 'hFFFF;
         r.found = (model_count >= g);
         if (r.found) begin
            for (int i = 0; i + g <= model_count; i++) begin
               d = int'(model_store[i+g-1]) - int'(model_store[i]);
               if (d < best) best = d;
            end
         end
         r.min_difference = r.found ? VW'(best) : '0;
         r.overflow       = model_dropped;
         expected_spread_q.push_back(r);
         model_count   = 0;
         model_dropped = 1'b0;
      end
   endfunction

   // result checker: every strobe is one transaction
   always @(posedge clock) begin : result_check
      spread_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_spread_q.size() == 0) begin
            $error("result with no set pending: min_difference %0d found %0b overflow %0b",
                   rsp_min_difference, rsp_found, rsp_overflow);
            err_count++;
         end else begin
            want = expected_spread_q.pop_front();
            if (rsp_min_difference !== want.min_difference) begin
               $error("min_difference: expected %0d, actual %0d",
                      want.min_difference, rsp_min_difference);
               err_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0b, actual %0b", want.found, rsp_found);
               err_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0b, actual %0b", want.overflow, rsp_overflow);
               err_count++;
            end
         end
      end
   end

   // one input transaction; start is left high for a following item
   task automatic send_item(input logic [VW-1:0] v, input logic last);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_value   <= v;
      req_is_last <= last;
      do @(posedge clock); while (busy);
      update_spread_model(v, last);
   endtask

   // drop start and let every pending result arrive
   task automatic wait_results_done();
      start <= 1'b0;
      while (expected_spread_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr write, only with the unit idle
   task automatic write_group_size(input logic [GW-1:0] g);
      wait_results_done();
      csr_valid      <= 1'b1;
      csr_group_size <= g;
      do @(posedge clock); while (!csr_ready);
      model_group = g;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one random set of n values, the last one closing it
   task automatic send_set(input int n, input int mode);
      logic [VW-1:0] v;
      int            base;
      base = $urandom_range(0, 65520);
      for (int i = 0; i < n; i++) begin
         case (mode)
            0: v = VW'($urandom);
            1: v = VW'(base + $urandom_range(0, 15));
            default: begin
               case ($urandom_range(0, 2))
                  0: v = '0;
                  1: v = '1;
                  default: v = VW'($urandom);
               endcase
            end
         endcase
         send_item(v, i == n - 1);
      end
      // now and then the sender holds off until the unit has answered
      if (idle_en && $urandom_range(0, 7) == 0) wait_results_done();
   endtask

   // reset value of group_size is 1
   task automatic test_reset_default();
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0000, 1'b1);
   endtask

   // group_size 0 behaves as 1
   task automatic test_zero_group();
      write_group_size(GW'(0));
      send_item(16'h1234, 1'b0);
      send_item(16'h0001, 1'b0);
      send_item(16'hFFFE, 1'b1);
   endtask

   // equal values sit side by side with no spread
   task automatic test_equal_values();
      write_group_size(GW'(2));
      send_item(16'h0000, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0064, 1'b0);
      send_item(16'hFFFF, 1'b1);
   endtask

   // fewer values than the group
   task automatic test_too_few();
      write_group_size(GW'(DEPTH));
      send_item(16'h00FF, 1'b0);
      send_item(16'hFF00, 1'b0);
      send_item(16'h5555, 1'b1);
   endtask

   // group_size beyond the store can never be met
   task automatic test_group_above_range();
      write_group_size(GW'(63));
      send_item(16'hAAAA, 1'b0);
      send_item(16'h5555, 1'b1);
   endtask

   // widest spread and single-value sets
   task automatic test_extremes();
      write_group_size(GW'(1));
      send_item(16'h0000, 1'b1);
      send_item(16'hFFFF, 1'b1);
      write_group_size(GW'(2));
      send_item(16'h0000, 1'b0);
      send_item(16'hFFFF, 1'b1);
   endtask

   // full store, dropped values and a dropped closing value
   task automatic test_store_full();
      write_group_size(GW'(DEPTH));
      send_set(DEPTH, 0);
      send_set(DEPTH + 2, 0);
      send_set(DEPTH + 1, 2);
      write_group_size(GW'(3));
      send_set(DEPTH + 5, 1);
   endtask

   // random sets over a sweep of group sizes
   task automatic test_random_sets();
      int group_list [12] = '{1, 2, 3, 5, 8, 16, 31, 32, 0, 63, 33, -1};
      int g;
      int n;
      int sent;
      foreach (group_list[p]) begin
         g = (group_list[p] < 0) ? $urandom_range(0, 63) : group_list[p];
         write_group_size(GW'(g));
         sent = 0;
         while (sent < 45) begin
            case ($urandom_range(0, 14))
               0:       n = $urandom_range(DEPTH - 4, DEPTH + 6);
               1, 2:    n = (g > 2) ? $urandom_range(g - 2, g + 2) : $urandom_range(1, 4);
               default: n = $urandom_range(1, 12);
            endcase
            send_set(n, $urandom_range(0, 2));
            sent += n;
         end
      end
   endtask

   // closing stretch with no gaps on the input
   task automatic test_back_to_back();
      int sent;
      int n;
      idle_en = 1'b0;
      write_group_size(GW'($urandom_range(1, 8)));
      sent = 0;
      while (sent < 80) begin
         n = $urandom_range(1, 10);
         send_set(n, $urandom_range(0, 2));
         sent += n;
      end
   endtask

   // test sequence
   initial begin
      model_count   = 0;
      model_dropped = 1'b0;
      model_group   = GW'(1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_default();
      test_zero_group();
      test_equal_values();
      test_too_few();
      test_group_above_range();
      test_extremes();
      test_store_full();
      test_random_sets();
      test_back_to_back();

      wait_results_done();
      repeat (40) @(posedge clock);
      if (expected_spread_q.size() != 0) begin
         $error("%0d results never arrived", expected_spread_q.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
